FILE: hw/rtl/kabf_pkg.sv
// ----------------------------------------------------------------------------
// kabf_pkg
// shared widths, register codes, reset values and saturation helper for the
// angle/bias kalman filter
// ----------------------------------------------------------------------------
`default_nettype none

package kabf_pkg;

  localparam int unsigned AngleW = 32;   // q16.16 angle, rate, state
  localparam int unsigned DtW    = 16;   // q0.16 time step
  localparam int unsigned NoiseW = 31;   // q7.24 unsigned noise registers
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgAngleNoise   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBiasNoise    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMeasureNoise = 2'd2;

  localparam logic [NoiseW-1:0] AngleNoiseRst   = 31'd16777;
  localparam logic [NoiseW-1:0] BiasNoiseRst    = 31'd50332;
  localparam logic [NoiseW-1:0] MeasureNoiseRst = 31'd503316;

  // clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/kalman_angle_bias_filter.sv
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter
// two-state (angle, gyro bias) kalman filter with bit-serial arithmetic
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one word per imu sample: tdata = measured_angle [31:0],
//   measured_rate [63:32], time_step [79:64]. m_axis returns one word per
//   sample: tdata = filtered_angle [31:0].
//   cfg channel writes the noise registers (index 0 angle, 1 bias,
//   2 measurement); other indexes are ignored. cfg_ready_o is always high.
// sequencing:
//   one sample at a time: ten products on a shared shift-add multiplier
//   and two gains on a restoring divider, each with its own load and
//   writeback; with the gains forced to zero the divides are skipped
// reset:
//   state estimates and covariance clear to zero, noise registers take
//   their defaults, no result is pending.
// stall:
//   a finished result waits in the output register; the next sample is
//   accepted meanwhile and its result waits for the register to drain.
// ----------------------------------------------------------------------------
`default_nettype none

module kalman_angle_bias_filter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [kabf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [kabf_pkg::CfgDataW-1:0] cfg_data_i,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // measured_angle[31:0], measured_rate[63:32], time_step[79:64]
  input  wire logic [79:0] s_axis_tdata,
  // output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // filtered_angle[31:0]
  output logic [31:0]      m_axis_tdata
);

  // sequencer states
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StLoad = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StWb   = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  // micro steps
  localparam logic [3:0] SpAngPred = 4'd0;   // dt*(rate-bias)
  localparam logic [3:0] SpDtP11   = 4'd1;   // dt*p11
  localparam logic [3:0] SpP00Pred = 4'd2;   // dt*inner
  localparam logic [3:0] SpP11Pred = 4'd3;   // bias_noise*dt
  localparam logic [3:0] SpK0      = 4'd4;   // n00/s
  localparam logic [3:0] SpK1      = 4'd5;   // n10/s
  localparam logic [3:0] SpAngCorr = 4'd6;   // k0*y
  localparam logic [3:0] SpBiasCor = 4'd7;   // k1*y
  localparam logic [3:0] SpC00     = 4'd8;   // k0*n00
  localparam logic [3:0] SpC01     = 4'd9;   // k0*n01
  localparam logic [3:0] SpC10     = 4'd10;  // k1*n00
  localparam logic [3:0] SpC11     = 4'd11;  // k1*n01

  localparam logic [5:0] MulLast = 6'd32;  // 33 multiplier bits
  localparam logic [5:0] DivLast = 6'd56;  // 57 dividend bits

  logic [2:0] state_q, state_d;
  logic [3:0] step_q, step_d;
  logic [5:0] cnt_q, cnt_d;

  // config registers
  logic [kabf_pkg::NoiseW-1:0] angle_noise_q, bias_noise_q, measure_noise_q;

  // filter state
  logic signed [31:0] angle_q, angle_d, bias_q, bias_d;
  logic signed [31:0] p00_q, p00_d, p01_q, p01_d, p10_q, p10_d, p11_q, p11_d;

  // per-sample work registers
  logic signed [31:0] meas_q, meas_d;
  logic signed [32:0] rate_q, rate_d;
  logic [15:0]        dt_q, dt_d;
  logic signed [35:0] inner_q, inner_d;
  logic signed [31:0] n00_q, n00_d, n01_q, n01_d, n10_q, n10_d, n11_q, n11_d;
  logic signed [33:0] s_q, s_d;
  logic signed [31:0] y_q, y_d, k0_q, k0_d, k1_q, k1_d;

  // serial multiplier
  logic [36:0] hi_q, hi_d;
  logic [32:0] lo_q, lo_d;
  logic [35:0] amag_q, amag_d;
  logic        mneg_q, mneg_d;
  logic        sh24_q, sh24_d;

  // serial divider, dvd holds the quotient once done
  logic [56:0] dvd_q, dvd_d;
  logic [33:0] rem_q, rem_d;
  logic        dneg_q, dneg_d;

  logic        out_valid_q, out_valid_d;
  logic [31:0] out_data_q, out_data_d;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // operand selection and rounding helpers
  logic signed [35:0] op_a;
  logic signed [32:0] op_b;
  logic signed [31:0] op_num;
  logic [35:0]        a_mag;
  logic [32:0]        b_mag;
  logic [31:0]        num_mag;
  logic [37:0]        msum;
  logic [69:0]        prod, prod_rnd;
  logic [53:0]        rmag;
  logic signed [55:0] mres;
  logic signed [63:0] m64;
  logic [33:0]        rem_sh;
  logic [34:0]        rdiff;
  logic [56:0]        qv;
  logic signed [31:0] dres;
  logic signed [63:0] t64;

  always_comb begin
    // operand mux
    op_a   = 36'sd0;
    op_b   = 33'sd0;
    op_num = n00_q;
    case (step_q)
      SpAngPred: begin op_a = 36'(rate_q);  op_b = {17'b0, dt_q}; end
      SpDtP11:   begin op_a = 36'(p11_q);   op_b = {17'b0, dt_q}; end
      SpP00Pred: begin op_a = inner_q;      op_b = {17'b0, dt_q}; end
      SpP11Pred: begin op_a = {5'b0, bias_noise_q}; op_b = {17'b0, dt_q}; end
      SpK0:      op_num = n00_q;
      SpK1:      op_num = n10_q;
      SpAngCorr: begin op_a = 36'(y_q);   op_b = 33'(k0_q); end
      SpBiasCor: begin op_a = 36'(y_q);   op_b = 33'(k1_q); end
      SpC00:     begin op_a = 36'(n00_q); op_b = 33'(k0_q); end
      SpC01:     begin op_a = 36'(n01_q); op_b = 33'(k0_q); end
      SpC10:     begin op_a = 36'(n00_q); op_b = 33'(k1_q); end
      SpC11:     begin op_a = 36'(n01_q); op_b = 33'(k1_q); end
      default: ;
    endcase
    a_mag   = op_a[35]   ? 36'(-op_a)   : 36'(op_a);
    b_mag   = op_b[32]   ? 33'(-op_b)   : 33'(op_b);
    num_mag = op_num[31] ? 32'(-op_num) : 32'(op_num);

    // multiplier step
    msum = {1'b0, hi_q} + (lo_q[0] ? {2'b0, amag_q} : 38'd0);

    // round to nearest, ties away from zero, on the magnitude
    prod     = {hi_q, lo_q};
    prod_rnd = sh24_q ? ((prod + 70'(1 << 23)) >> 24) : ((prod + 70'(1 << 15)) >> 16);
    rmag     = prod_rnd[53:0];
    mres     = mneg_q ? -$signed({2'b0, rmag}) : $signed({2'b0, rmag});
    m64      = {{8{mres[55]}}, mres};

    // divider step
    rem_sh = {rem_q[32:0], dvd_q[56]};
    rdiff  = {1'b0, rem_sh} - {2'b0, s_q[32:0]};

    // gain saturation
    qv = dvd_q;
    if (dneg_q) begin
      if (qv > 57'h8000_0000) qv = 57'h8000_0000;
      dres = 32'(-$signed({1'b0, qv[32:0]}));
    end else begin
      if (qv > 57'h7fff_ffff) qv = 57'h7fff_ffff;
      dres = $signed(qv[31:0]);
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cnt_d   = cnt_q;
    angle_d = angle_q;  bias_d = bias_q;
    p00_d = p00_q; p01_d = p01_q; p10_d = p10_q; p11_d = p11_q;
    meas_d = meas_q; rate_d = rate_q; dt_d = dt_q; inner_d = inner_q;
    n00_d = n00_q; n01_d = n01_q; n10_d = n10_q; n11_d = n11_q;
    s_d = s_q; y_d = y_q; k0_d = k0_q; k1_d = k1_q;
    hi_d = hi_q; lo_d = lo_q; amag_d = amag_q; mneg_d = mneg_q; sh24_d = sh24_q;
    dvd_d = dvd_q; rem_d = rem_q; dneg_d = dneg_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    t64 = 64'sd0;

    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          meas_d  = $signed(s_axis_tdata[31:0]);
          rate_d  = 33'($signed(s_axis_tdata[63:32])) - 33'(bias_q);
          dt_d    = s_axis_tdata[79:64];
          step_d  = SpAngPred;
          state_d = StLoad;
        end
      end
      StLoad: begin
        cnt_d = 6'd0;
        if (step_q == SpK0 || step_q == SpK1) begin
          dvd_d   = {1'b0, num_mag, 24'b0} + {25'b0, s_q[32:1]};
          rem_d   = 34'd0;
          dneg_d  = op_num[31];
          state_d = StDiv;
        end else begin
          hi_d    = 37'd0;
          lo_d    = b_mag;
          amag_d  = a_mag;
          mneg_d  = op_a[35] ^ op_b[32];
          sh24_d  = (step_q >= SpAngCorr);
          state_d = StMul;
        end
      end
      StMul: begin
        hi_d  = msum[37:1];
        lo_d  = {msum[0], lo_q[32:1]};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == MulLast) state_d = StWb;
      end
      StDiv: begin
        if (!rdiff[34]) begin
          rem_d = rdiff[33:0];
          dvd_d = {dvd_q[55:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          dvd_d = {dvd_q[55:0], 1'b0};
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == DivLast) state_d = StWb;
      end
      StWb: begin
        step_d  = step_q + 4'd1;
        state_d = StLoad;
        case (step_q)
          SpAngPred: angle_d = kabf_pkg::sat32(64'(angle_q) + m64);
          SpDtP11: begin
            t64     = m64 - 64'(p01_q) - 64'(p10_q) + 64'(angle_noise_q);
            inner_d = t64[35:0];
            n01_d   = kabf_pkg::sat32(64'(p01_q) - m64);
            n10_d   = kabf_pkg::sat32(64'(p10_q) - m64);
          end
          SpP00Pred: n00_d = kabf_pkg::sat32(64'(p00_q) + m64);
          SpP11Pred: begin
            n11_d = kabf_pkg::sat32(64'(p11_q) + m64);
            s_d   = 34'(n00_q) + 34'(measure_noise_q);
            t64   = 64'(meas_q) - 64'(angle_q);
            y_d   = kabf_pkg::sat32(t64);
            // non-positive innovation variance: zero gains, skip the divides
            if ($signed(34'(n00_q) + 34'(measure_noise_q)) <= 34'sd0) begin
              k0_d   = 32'sd0;
              k1_d   = 32'sd0;
              step_d = SpAngCorr;
            end
          end
          SpK0:      k0_d = dres;
          SpK1:      k1_d = dres;
          SpAngCorr: angle_d = kabf_pkg::sat32(64'(angle_q) + m64);
          SpBiasCor: bias_d  = kabf_pkg::sat32(64'(bias_q) + m64);
          SpC00:     p00_d   = kabf_pkg::sat32(64'(n00_q) - m64);
          SpC01:     p01_d   = kabf_pkg::sat32(64'(n01_q) - m64);
          SpC10:     p10_d   = kabf_pkg::sat32(64'(n10_q) - m64);
          SpC11: begin
            p11_d   = kabf_pkg::sat32(64'(n11_q) - m64);
            state_d = StOut;
          end
          default: ;
        endcase
      end
      StOut: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = angle_q;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control, state and config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= StIdle;
      step_q          <= SpAngPred;
      cnt_q           <= 6'd0;
      out_valid_q     <= 1'b0;
      angle_q         <= 32'sd0;
      bias_q          <= 32'sd0;
      p00_q           <= 32'sd0;
      p01_q           <= 32'sd0;
      p10_q           <= 32'sd0;
      p11_q           <= 32'sd0;
      angle_noise_q   <= kabf_pkg::AngleNoiseRst;
      bias_noise_q    <= kabf_pkg::BiasNoiseRst;
      measure_noise_q <= kabf_pkg::MeasureNoiseRst;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      angle_q     <= angle_d;
      bias_q      <= bias_d;
      p00_q       <= p00_d;
      p01_q       <= p01_d;
      p10_q       <= p10_d;
      p11_q       <= p11_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          kabf_pkg::CfgAngleNoise:   angle_noise_q   <= cfg_data_i[30:0];
          kabf_pkg::CfgBiasNoise:    bias_noise_q    <= cfg_data_i[30:0];
          kabf_pkg::CfgMeasureNoise: measure_noise_q <= cfg_data_i[30:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    meas_d_reg: begin
    end
    meas_q     <= meas_d;
    rate_q     <= rate_d;
    dt_q       <= dt_d;
    inner_q    <= inner_d;
    n00_q      <= n00_d;
    n01_q      <= n01_d;
    n10_q      <= n10_d;
    n11_q      <= n11_d;
    s_q        <= s_d;
    y_q        <= y_d;
    k0_q       <= k0_d;
    k1_q       <= k1_d;
    hi_q       <= hi_d;
    lo_q       <= lo_d;
    amag_q     <= amag_d;
    mneg_q     <= mneg_d;
    sh24_q     <= sh24_d;
    dvd_q      <= dvd_d;
    rem_q      <= rem_d;
    dneg_q     <= dneg_d;
    out_data_q <= out_data_d;
  end

endmodule

`default_nettype wire
